// ===== rtl/ifd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Shared widths, codes and microcode table of the interpolated fractional delay.
// No dependencies; imported by the channel interfaces and the top level.

package ifd_pkg;

    localparam int SAMPLE_W = 24;
    localparam int DELAY_W  = 20;
    localparam int FRAC_W   = 8;
    localparam int MODE_W   = 2;

    // Accumulator holds the largest Hermite coefficient sum with margin.
    localparam int ACC_W    = SAMPLE_W + 6;
    localparam int PROD_W   = ACC_W + FRAC_W + 1;
    localparam int STEP_W   = 4;

    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((64'sd1 <<< (SAMPLE_W - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-(64'sd1 <<< (SAMPLE_W - 1)));
    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(64'sd1 <<< (FRAC_W - 1));

    typedef enum logic [MODE_W-1:0] {
        MODE_LINEAR    = 2'd0,
        MODE_HERMITE   = 2'd1,
        MODE_CUBIC     = 2'd2,
        MODE_CUBIC_ALT = 2'd3
    } interp_mode_t;

    // Neighbor taps around the integer read index: tap 1 is the index itself.
    typedef enum logic [1:0] {
        TAP0 = 2'd0,
        TAP1 = 2'd1,
        TAP2 = 2'd2,
        TAP3 = 2'd3
    } tap_t;

    typedef enum logic [1:0] {
        ACC_HOLD = 2'd0,
        ACC_LOAD = 2'd1,
        ACC_ADD  = 2'd2
    } acc_op_t;

    typedef enum logic [2:0] {
        COND_NEXT     = 3'd0,
        COND_NO_WORD  = 3'd1,
        COND_LINEAR   = 3'd2,
        COND_OUT_BUSY = 3'd3,
        COND_ALWAYS   = 3'd4
    } seq_cond_t;

    typedef logic [STEP_W-1:0] step_t;

    localparam step_t ST_IDLE  = 4'd0;
    localparam step_t ST_RD0   = 4'd1;
    localparam step_t ST_RD1   = 4'd2;
    localparam step_t ST_RD2   = 4'd3;
    localparam step_t ST_RD3   = 4'd4;
    localparam step_t ST_WR    = 4'd5;
    localparam step_t ST_COEF0 = 4'd6;
    localparam step_t ST_LOAD  = 4'd7;
    localparam step_t ST_MUL0  = 4'd8;
    localparam step_t ST_ADD0  = 4'd9;
    localparam step_t ST_MUL1  = 4'd10;
    localparam step_t ST_ADD1  = 4'd11;
    localparam step_t ST_MUL2  = 4'd12;
    localparam step_t ST_ADD2  = 4'd13;
    localparam step_t ST_OUT   = 4'd14;
    localparam step_t ST_RET   = 4'd15;

    typedef struct packed {
        logic      in_rdy;
        logic      rd_en;
        tap_t      rd_tap;
        logic      cap_en;
        tap_t      cap_tap;
        logic      wr_en;
        logic      coef_en;
        tap_t      coef_slot;
        acc_op_t   acc_op;
        logic      mul_en;
        logic      out_en;
        seq_cond_t cond;
        step_t     target;
    } ctrl_word_t;

    localparam ctrl_word_t CW_NOP = '{
        in_rdy:    1'b0,
        rd_en:     1'b0,
        rd_tap:    TAP0,
        cap_en:    1'b0,
        cap_tap:   TAP0,
        wr_en:     1'b0,
        coef_en:   1'b0,
        coef_slot: TAP0,
        acc_op:    ACC_HOLD,
        mul_en:    1'b0,
        out_en:    1'b0,
        cond:      COND_NEXT,
        target:    ST_IDLE
    };

    // Microcode ROM: one control word per step.
    function automatic ctrl_word_t ucode_rom(input step_t step);
        ctrl_word_t cw;
        cw = CW_NOP;
        case (step)
            ST_IDLE:
            begin
                cw.in_rdy = 1'b1;
                cw.cond   = COND_NO_WORD;
                cw.target = ST_IDLE;
            end
            ST_RD0:
            begin
                cw.rd_en  = 1'b1;
                cw.rd_tap = TAP0;
            end
            ST_RD1:
            begin
                cw.rd_en   = 1'b1;
                cw.rd_tap  = TAP1;
                cw.cap_en  = 1'b1;
                cw.cap_tap = TAP0;
            end
            ST_RD2:
            begin
                cw.rd_en   = 1'b1;
                cw.rd_tap  = TAP2;
                cw.cap_en  = 1'b1;
                cw.cap_tap = TAP1;
            end
            ST_RD3:
            begin
                cw.rd_en   = 1'b1;
                cw.rd_tap  = TAP3;
                cw.cap_en  = 1'b1;
                cw.cap_tap = TAP2;
            end
            ST_WR:
            begin
                cw.wr_en   = 1'b1;
                cw.cap_en  = 1'b1;
                cw.cap_tap = TAP3;
            end
            ST_COEF0:
            begin
                cw.coef_en   = 1'b1;
                cw.coef_slot = TAP0;
            end
            ST_LOAD:
            begin
                cw.acc_op    = ACC_LOAD;
                cw.coef_en   = 1'b1;
                cw.coef_slot = TAP1;
            end
            ST_MUL0:
            begin
                cw.mul_en = 1'b1;
                cw.cond   = COND_LINEAR;
                cw.target = ST_ADD2;
            end
            ST_ADD0:
            begin
                cw.acc_op    = ACC_ADD;
                cw.coef_en   = 1'b1;
                cw.coef_slot = TAP2;
            end
            ST_MUL1:
            begin
                cw.mul_en = 1'b1;
            end
            ST_ADD1:
            begin
                cw.acc_op    = ACC_ADD;
                cw.coef_en   = 1'b1;
                cw.coef_slot = TAP3;
            end
            ST_MUL2:
            begin
                cw.mul_en = 1'b1;
            end
            ST_ADD2:
            begin
                cw.acc_op = ACC_ADD;
            end
            ST_OUT:
            begin
                cw.out_en = 1'b1;
                cw.cond   = COND_OUT_BUSY;
                cw.target = ST_OUT;
            end
            ST_RET:
            begin
                cw.cond   = COND_ALWAYS;
                cw.target = ST_IDLE;
            end
            default:
            begin
                cw = CW_NOP;
            end
        endcase
        return cw;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ifd_channels.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Valid/ready channel interfaces: input word, result word and mode register write.
// Depends on ifd_pkg for field widths.

interface ifd_in_if
    import ifd_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic        [DELAY_W-1:0]  delay_amount;

    modport source (output valid, output sample_in, output delay_amount, input ready);
    modport sink   (input valid, input sample_in, input delay_amount, output ready);
endinterface

interface ifd_out_if
    import ifd_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

interface ifd_cfg_if
    import ifd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] interp_mode;

    modport source (output valid, output interp_mode, input ready);
    modport sink   (input valid, input interp_mode, output ready);
endinterface

`default_nettype wire

// ===== rtl/interpolated_fractional_delay_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Top level of the interpolated fractional delay: circular sample store with a
// microcoded sequencer driving one multiply-round-add datapath. Uses ifd_pkg, ifd_channels.
//
//  channel | modport | payload                     | word accepted when
//  --------+---------+-----------------------------+--------------------------
//  feed    | sink    | sample_in, delay_amount     | feed.valid & feed.ready
//  result  | source  | sample_out                  | result.valid & result.ready
//  cfg     | sink    | interp_mode                 | cfg.valid (ready always high)
//
//  Sequence: the microcode program runs four reads and one write through the single
//  store port, then three multiply/round/add passes through one multiplier (one
//  pass in linear mode).
//  Reset: rst_n clears control state and starts a clearing pass that zeroes the
//  store; feed.ready stays low until it ends.
//  Stalls: a finished result waits in the output register; the sequencer holds at
//  its output step only while that register is occupied and result.ready is low.

module interpolated_fractional_delay_unit
    import ifd_pkg::*;
#(
    parameter int STORE_DEPTH = 4096
)
(
    input  wire       clk,
    input  wire       rst_n,
    ifd_in_if.sink    feed,
    ifd_out_if.source result,
    ifd_cfg_if.sink   cfg
);

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int PW = (((AW + FRAC_W) > DELAY_W) ? (AW + FRAC_W) : DELAY_W) + 1;
    localparam logic [PW-1:0] DELAY_LIMIT = PW'(STORE_DEPTH - 4) << FRAC_W;
    localparam logic [PW-1:0] SPAN        = PW'(STORE_DEPTH) << FRAC_W;
    localparam logic [AW-1:0] LAST_ADDR   = AW'(STORE_DEPTH - 1);
    localparam logic signed [ACC_W-1:0] ACC_ONE = ACC_W'(1);

    // Sample store: one port, registered read.
    logic [SAMPLE_W-1:0] store_mem [STORE_DEPTH];
    logic [SAMPLE_W-1:0] rd_data_reg;
    logic [AW-1:0]       mem_addr;
    logic                mem_we;
    logic [SAMPLE_W-1:0] mem_wdata;

    // Sequencer and control state.
    step_t               step_reg, step_next;
    ctrl_word_t          cw;
    logic                clear_busy_reg, clear_busy_next;
    logic [AW-1:0]       clear_addr_reg, clear_addr_next;
    logic [AW-1:0]       wp_reg, wp_next;
    interp_mode_t        mode_reg, mode_next;
    logic                out_valid_reg, out_valid_next;

    // Datapath registers.
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic [FRAC_W-1:0]          frac_reg;
    logic [AW-1:0]              tap1_reg;
    logic signed [SAMPLE_W-1:0] y_reg [4];
    logic signed [ACC_W-1:0]    coef_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [SAMPLE_W-1:0] out_data_reg;

    // Combinational nets.
    logic                       accept;
    logic                       out_busy;
    logic                       is_linear;
    logic [PW-1:0]              wp_fixed;
    logic [PW-1:0]              delay_ext;
    logic [PW-1:0]              delay_cl;
    logic [PW-1:0]              pos;
    logic [PW-FRAC_W-1:0]       pos_int;
    logic [AW-1:0]              tap1_new;
    logic [AW-1:0]              tap0_addr, tap2_addr, tap3_addr, rd_addr;
    logic signed [ACC_W-1:0]    ye0, ye1, ye2, ye3;
    logic signed [ACC_W-1:0]    coef_val;
    logic signed [PROD_W-1:0]   prod_val;
    logic signed [PROD_W-1:0]   round_sum;
    logic signed [PROD_W-1:0]   round_shift;
    logic signed [ACC_W-1:0]    rounded;
    logic signed [ACC_W-1:0]    half_sum;
    logic signed [ACC_W-1:0]    final_val;
    logic signed [SAMPLE_W-1:0] sat_val;

    assign cw        = ucode_rom(step_reg);
    assign is_linear = (mode_reg == MODE_LINEAR);
    assign out_busy  = out_valid_reg && !result.ready;

    assign feed.ready        = cw.in_rdy && !clear_busy_reg;
    assign accept            = feed.valid && feed.ready;
    assign cfg.ready         = 1'b1;
    assign result.valid      = out_valid_reg;
    assign result.sample_out = out_data_reg;

    // Read position: write position minus clamped delay, wrapped into the store.
    always_comb
    begin
        wp_fixed  = PW'(wp_reg) << FRAC_W;
        delay_ext = PW'(feed.delay_amount);
        delay_cl  = (delay_ext > DELAY_LIMIT) ? DELAY_LIMIT : delay_ext;
        pos       = wp_fixed - delay_cl + ((wp_fixed < delay_cl) ? SPAN : '0);
        pos_int   = pos[PW-1:FRAC_W];
        tap1_new  = (pos_int >= (PW-FRAC_W)'(STORE_DEPTH)) ? '0 : pos_int[AW-1:0];
    end

    // Neighbor addresses with wraparound.
    always_comb
    begin
        tap0_addr = (tap1_reg == '0) ? LAST_ADDR : tap1_reg - AW'(1);
        tap2_addr = (tap1_reg == LAST_ADDR) ? '0 : tap1_reg + AW'(1);
        tap3_addr = (tap2_addr == LAST_ADDR) ? '0 : tap2_addr + AW'(1);
        case (cw.rd_tap)
            TAP0:    rd_addr = tap0_addr;
            TAP1:    rd_addr = tap1_reg;
            TAP2:    rd_addr = tap2_addr;
            TAP3:    rd_addr = tap3_addr;
            default: rd_addr = tap1_reg;
        endcase
    end

    // Store port arbitration: the clearing pass owns the port until it ends.
    always_comb
    begin
        if (clear_busy_reg)
        begin
            mem_addr  = clear_addr_reg;
            mem_we    = 1'b1;
            mem_wdata = '0;
        end
        else if (cw.wr_en)
        begin
            mem_addr  = wp_reg;
            mem_we    = 1'b1;
            mem_wdata = sample_reg;
        end
        else
        begin
            mem_addr  = rd_addr;
            mem_we    = 1'b0;
            mem_wdata = sample_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[mem_addr] <= mem_wdata;
        end
        else if (cw.rd_en)
        begin
            rd_data_reg <= store_mem[mem_addr];
        end
    end

    // Coefficient for the selected slot; the mode picks the polynomial.
    always_comb
    begin
        ye0 = ACC_W'(y_reg[0]);
        ye1 = ACC_W'(y_reg[1]);
        ye2 = ACC_W'(y_reg[2]);
        ye3 = ACC_W'(y_reg[3]);
        coef_val = ye1;
        case (mode_reg)
            MODE_LINEAR:
            begin
                case (cw.coef_slot)
                    TAP0:    coef_val = ye2 - ye1;
                    default: coef_val = ye1;
                endcase
            end
            MODE_HERMITE:
            begin
                case (cw.coef_slot)
                    TAP0:    coef_val = ye3 - ye0 + (ye1 <<< 1) + ye1 - (ye2 <<< 1) - ye2;
                    TAP1:    coef_val = (ye0 <<< 1) - (ye1 <<< 2) - ye1 + (ye2 <<< 2) - ye3;
                    TAP2:    coef_val = ye2 - ye0;
                    default: coef_val = ye1 <<< 1;
                endcase
            end
            default:
            begin
                case (cw.coef_slot)
                    TAP0:    coef_val = ye3 - ye2 - ye0 + ye1;
                    TAP1:    coef_val = (ye0 <<< 1) - (ye1 <<< 1) + ye2 - ye3;
                    TAP2:    coef_val = ye2 - ye0;
                    default: coef_val = ye1;
                endcase
            end
        endcase
    end

    // Multiply, round half up, and the output stage.
    always_comb
    begin
        prod_val    = acc_reg * $signed({1'b0, frac_reg});
        round_sum   = prod_reg + ROUND_HALF;
        round_shift = round_sum >>> FRAC_W;
        rounded     = $signed(round_shift[ACC_W-1:0]);
        half_sum    = acc_reg + ACC_ONE;
        final_val   = (mode_reg == MODE_HERMITE) ? (half_sum >>> 1) : acc_reg;
        if (final_val > SAT_HI)
        begin
            sat_val = SAT_HI[SAMPLE_W-1:0];
        end
        else if (final_val < SAT_LO)
        begin
            sat_val = SAT_LO[SAMPLE_W-1:0];
        end
        else
        begin
            sat_val = final_val[SAMPLE_W-1:0];
        end
    end

    // Next step: jump on the control word's condition, else advance.
    always_comb
    begin
        case (cw.cond)
            COND_NO_WORD:  step_next = accept ? step_reg + STEP_W'(1) : cw.target;
            COND_LINEAR:   step_next = is_linear ? cw.target : step_reg + STEP_W'(1);
            COND_OUT_BUSY: step_next = out_busy ? cw.target : step_reg + STEP_W'(1);
            COND_ALWAYS:   step_next = cw.target;
            default:       step_next = step_reg + STEP_W'(1);
        endcase
    end

    always_comb
    begin
        clear_busy_next = clear_busy_reg;
        clear_addr_next = clear_addr_reg;
        if (clear_busy_reg)
        begin
            clear_addr_next = clear_addr_reg + AW'(1);
            if (clear_addr_reg == LAST_ADDR)
            begin
                clear_busy_next = 1'b0;
            end
        end

        wp_next = wp_reg;
        if (cw.wr_en && !clear_busy_reg)
        begin
            wp_next = (wp_reg == LAST_ADDR) ? '0 : wp_reg + AW'(1);
        end

        mode_next = mode_reg;
        if (cfg.valid)
        begin
            mode_next = interp_mode_t'(cfg.interp_mode);
        end

        out_valid_next = out_valid_reg;
        if (cw.out_en && !out_busy)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg       <= ST_IDLE;
            clear_busy_reg <= 1'b1;
            clear_addr_reg <= '0;
            wp_reg         <= '0;
            mode_reg       <= MODE_CUBIC;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            step_reg       <= step_next;
            clear_busy_reg <= clear_busy_next;
            clear_addr_reg <= clear_addr_next;
            wp_reg         <= wp_next;
            mode_reg       <= mode_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers: no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg <= feed.sample_in;
            frac_reg   <= pos[FRAC_W-1:0];
            tap1_reg   <= tap1_new;
        end
        if (cw.cap_en)
        begin
            y_reg[cw.cap_tap] <= rd_data_reg;
        end
        if (cw.coef_en)
        begin
            coef_reg <= coef_val;
        end
        case (cw.acc_op)
            ACC_LOAD: acc_reg <= coef_reg;
            ACC_ADD:  acc_reg <= rounded + coef_reg;
            default:  acc_reg <= acc_reg;
        endcase
        if (cw.mul_en)
        begin
            prod_reg <= prod_val;
        end
        if (cw.out_en && !out_busy)
        begin
            out_data_reg <= sat_val;
        end
    end

endmodule

`default_nettype wire
